>>> rtl/core/flm_pkg.sv
// Shared types and constants for the frame luminance meter.
// Holds the sequencer state type, the control and status words between the
// sequencer and the datapath, luma weights and register indexes. No dependencies.
package flm_pkg;

    // field and datapath widths
    localparam int COMP_W    = 16;
    localparam int FMT_W     = 2;
    localparam int CFG_PIX_W = 23;
    localparam int RATE_W    = 16;
    localparam int MEAN_W    = 24;
    localparam int SUM_W     = 56;
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_ITERS = MEAN_W + 1;
    localparam int ITER_W    = 5;
    localparam int LANE_W    = 2;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Rec.709 weights in Q0.16, mono passes comp0 at unity
    localparam logic [MUL_B_W-1:0] W_RED   = 17'd13933;
    localparam logic [MUL_B_W-1:0] W_GREEN = 17'd46871;
    localparam logic [MUL_B_W-1:0] W_BLUE  = 17'd4732;
    localparam logic [MUL_B_W-1:0] W_MONO  = 17'd65536;

    // rounding constant for the Q0.16 smoothing product
    localparam logic [PROD_W-1:0] ROUND_HALF = 41'd32768;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_MONO = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BGR  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;
    localparam logic [1:0] REG_RATE   = 2'd3;

    // register reset values
    localparam logic [FMT_W-1:0]     RST_FORMAT = FMT_MONO;
    localparam logic [CFG_PIX_W-1:0] RST_STEP   = 23'd1;
    localparam logic [CFG_PIX_W-1:0] RST_COUNT  = 23'd76800;
    localparam logic [RATE_W-1:0]    RST_RATE   = 16'd41427;

    // multiplier lanes for a colour pixel
    localparam logic [LANE_W-1:0] LANE_RED   = 2'd0;
    localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
    localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_MEAN,
        ST_SMUL,
        ST_SADD,
        ST_OUT
    } state_t;

    // sequencer to datapath
    typedef struct packed {
        logic              pix_load;
        logic              mul_issue;
        logic              acc;
        logic              div_load;
        logic              div_iter;
        logic              mean_load;
        logic              smul;
        logic              sadd;
        logic              out_load;
        logic [LANE_W-1:0] lane;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic sample_now;
        logic eof_in;
        logic eof_reg;
        logic colour;
    } stat_t;

endpackage

>>> rtl/core/flm_seq.sv
// Sequencer of the frame luminance meter: walks the shared multiplier
// over the luma lanes, the bit-serial divider and the smoothing steps.
// Depends on flm_pkg.
module flm_seq import flm_pkg::*; (
    input  logic  clk,
    input  logic  rstn,
    input  logic  in_valid,
    input  logic  out_free,
    input  stat_t stat,
    output logic  in_ready,
    output ctrl_t ctrl
);

    state_t              state_reg, state_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    // state and counters
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            lane_reg  <= LANE_RED;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            iter_reg  <= iter_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                lane_next = LANE_RED;
                if (in_valid) begin
                    if (stat.sample_now) begin
                        state_next = ST_MUL;
                    end else if (stat.eof_in) begin
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (stat.colour && (lane_reg != LANE_BLUE)) begin
                    lane_next  = lane_reg + 1'b1;
                    state_next = ST_MUL;
                end else if (stat.eof_reg) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD: begin
                iter_next  = ITER_W'(DIV_ITERS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (iter_reg == '0) begin
                    state_next = ST_MEAN;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_MEAN: state_next = ST_SMUL;
            ST_SMUL: state_next = ST_SADD;
            ST_SADD: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl           = '0;
        ctrl.lane      = lane_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                ctrl.pix_load = in_valid;
            end
            ST_MUL:      ctrl.mul_issue = 1'b1;
            ST_ACC:      ctrl.acc       = 1'b1;
            ST_DIV_LOAD: ctrl.div_load  = 1'b1;
            ST_DIV:      ctrl.div_iter  = 1'b1;
            ST_MEAN:     ctrl.mean_load = 1'b1;
            ST_SMUL:     ctrl.smul      = 1'b1;
            ST_SADD:     ctrl.sadd      = 1'b1;
            ST_OUT:      ctrl.out_load  = out_free;
            default:     ctrl.pix_load  = 1'b0;
        endcase
    end

    // at most one datapath operation per cycle
    a_one_op: assert property (@(posedge clk) disable iff (!rstn)
        $onehot0({ctrl.pix_load, ctrl.mul_issue, ctrl.acc, ctrl.div_load, ctrl.div_iter,
                  ctrl.mean_load, ctrl.smul, ctrl.sadd, ctrl.out_load}))
        else $error("flm_seq: more than one datapath operation");

    // a sampled pixel starts at the red (or mono) lane
    a_sample_start: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_IDLE && in_valid && stat.sample_now)
        |=> (state_reg == ST_MUL && lane_reg == LANE_RED))
        else $error("flm_seq: sampled pixel did not start at first lane");

    // divider hands over to the mean step once its step counter reaches zero
    a_div_end: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_DIV && iter_reg == '0) |=> (state_reg == ST_MEAN))
        else $error("flm_seq: divider did not finish");

    // result handed off returns the block to idle
    a_out_done: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_OUT && out_free) |=> (state_reg == ST_IDLE))
        else $error("flm_seq: result load did not return to idle");

endmodule

>>> rtl/core/flm_datapath.sv
// Datapath of the frame luminance meter: sample selection, shared multiplier,
// luma accumulator, restoring divider and smoothed mean register.
// Depends on flm_pkg; driven by flm_seq.
module flm_datapath import flm_pkg::*; #(
    parameter int COMPONENT_BITS   = 16,
    parameter int MAX_FRAME_PIXELS = 4194304
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  ctrl_t                ctrl,
    input  logic [COMP_W-1:0]    comp0,
    input  logic [COMP_W-1:0]    comp1,
    input  logic [COMP_W-1:0]    comp2,
    input  logic                 end_of_frame,
    input  logic [FMT_W-1:0]     cfg_format,
    input  logic [CFG_PIX_W-1:0] cfg_step,
    input  logic [CFG_PIX_W-1:0] cfg_count,
    input  logic [RATE_W-1:0]    cfg_rate,
    output stat_t                stat,
    output logic [MEAN_W-1:0]    frame_mean,
    output logic [MEAN_W-1:0]    smoothed_mean
);

    localparam logic [COMP_W-1:0]    COMP_MASK = {COMP_W{1'b1}} >> (COMP_W - COMPONENT_BITS);
    localparam logic [CFG_PIX_W+1:0] MAX_PIX   = (CFG_PIX_W + 2)'(MAX_FRAME_PIXELS);

    logic [COMP_W-1:0]    c0_reg, c1_reg, c2_reg;
    logic                 eof_reg;
    logic [CFG_PIX_W-1:0] phase_reg, taken_reg;
    logic [SUM_W-1:0]     sum_reg, rem_reg, dsh_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DIV_ITERS-1:0] quo_reg;
    logic [MEAN_W-1:0]    mean_reg, avg_reg;
    logic                 avg_valid_reg;

    logic [CFG_PIX_W-1:0] step_clamp, eff_step, eff_count, phase_inc;
    logic                 colour, sample_now;
    logic [COMP_W-1:0]    red_c, blue_c;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_full, rounded;
    logic                 mean_ge, rem_ge;
    logic [MEAN_W-1:0]    diff, step_amt;

    // clamp registers to the frame size limit, zero step acts as one
    always_comb begin
        step_clamp = ({2'b00, cfg_step} > MAX_PIX) ? MAX_PIX[CFG_PIX_W-1:0] : cfg_step;
        eff_step   = (step_clamp == '0) ? CFG_PIX_W'(1) : step_clamp;
        eff_count  = ({2'b00, cfg_count} > MAX_PIX) ? MAX_PIX[CFG_PIX_W-1:0] : cfg_count;
        phase_inc  = phase_reg + 1'b1;
    end

    assign colour     = (cfg_format == FMT_RGB) || (cfg_format == FMT_BGR);
    assign sample_now = (phase_reg == '0) && (taken_reg < eff_count);

    assign stat.sample_now = sample_now;
    assign stat.eof_in     = end_of_frame;
    assign stat.eof_reg    = eof_reg;
    assign stat.colour     = colour;

    // pixel capture and sample position
    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg <= '0;
            taken_reg <= '0;
            eof_reg   <= 1'b0;
        end else begin
            if (ctrl.pix_load) begin
                eof_reg <= end_of_frame;
                if (end_of_frame || (phase_inc >= eff_step)) begin
                    phase_reg <= '0;
                end else begin
                    phase_reg <= phase_inc;
                end
                if (sample_now) begin
                    taken_reg <= taken_reg + 1'b1;
                end
            end
            if (ctrl.div_load) begin
                taken_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.pix_load) begin
            c0_reg <= comp0 & COMP_MASK;
            c1_reg <= comp1 & COMP_MASK;
            c2_reg <= comp2 & COMP_MASK;
        end
    end

    // shared multiplier operand select
    always_comb begin
        red_c   = (cfg_format == FMT_BGR) ? c2_reg : c0_reg;
        blue_c  = (cfg_format == FMT_BGR) ? c0_reg : c2_reg;
        mean_ge = (mean_reg >= avg_reg);
        diff    = mean_ge ? (mean_reg - avg_reg) : (avg_reg - mean_reg);
        if (ctrl.smul) begin
            mul_a = diff;
            mul_b = {1'b0, cfg_rate};
        end else if (!colour) begin
            mul_a = MUL_A_W'(c0_reg);
            mul_b = W_MONO;
        end else begin
            case (ctrl.lane)
                LANE_RED: begin
                    mul_a = MUL_A_W'(red_c);
                    mul_b = W_RED;
                end
                LANE_GREEN: begin
                    mul_a = MUL_A_W'(c1_reg);
                    mul_b = W_GREEN;
                end
                default: begin
                    mul_a = MUL_A_W'(blue_c);
                    mul_b = W_BLUE;
                end
            endcase
        end
        mul_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk) begin
        if (ctrl.mul_issue || ctrl.smul) begin
            prod_reg <= mul_full;
        end
    end

    // luma accumulator
    always_ff @(posedge clk) begin
        if (!rstn) begin
            sum_reg <= '0;
        end else if (ctrl.acc) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end else if (ctrl.div_load) begin
            sum_reg <= '0;
        end
    end

    // restoring divider, one quotient bit per cycle; top bit flags saturation
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk) begin
        if (ctrl.div_load) begin
            rem_reg <= sum_reg + SUM_W'({eff_count, 7'd0});
            dsh_reg <= SUM_W'({eff_count, 32'd0});
            quo_reg <= '0;
        end else if (ctrl.div_iter) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[DIV_ITERS-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.mean_load) begin
            if (eff_count == '0) begin
                mean_reg <= '0;
            end else if (quo_reg[DIV_ITERS-1]) begin
                mean_reg <= {MEAN_W{1'b1}};
            end else begin
                mean_reg <= quo_reg[MEAN_W-1:0];
            end
        end
    end

    // smoothed mean: first frame loads, later frames step toward the mean
    assign rounded  = prod_reg + ROUND_HALF;
    assign step_amt = rounded[MEAN_W+15:16];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end else if (ctrl.sadd) begin
            avg_valid_reg <= 1'b1;
            if (!avg_valid_reg) begin
                avg_reg <= mean_reg;
            end else if (mean_ge) begin
                avg_reg <= avg_reg + step_amt;
            end else begin
                avg_reg <= avg_reg - step_amt;
            end
        end
    end

    assign frame_mean    = mean_reg;
    assign smoothed_mean = avg_reg;

endmodule

>>> rtl/core/frame_luminance_meter.sv
// Frame luminance meter top level: configuration registers, result register,
// sequencer and datapath.
// Depends on flm_pkg, flm_seq and flm_datapath.
//
// Usage: pixels enter on the s_ channel (valid/ready), one word per pixel with
// three components and an end-of-frame flag. Every sample_step-th pixel is
// sampled until sample_count samples are taken; its luma goes into a sum.
// On the end-of-frame word one result word leaves on the m_ channel with the
// frame mean and the smoothed mean, both Q16.8.
// An unsampled pixel needs no step past idle; a sampled pixel runs a multiply
// and an accumulate step per lane, one lane for mono and three for colour: one
// multiplier serves the three weights. The end-of-frame word then runs the
// bit-serial divider, the smoothing multiply and add and the result load.
// s_ready is high only while the sequencer is idle.
// A finished result waits in an output register; pixels keep being accepted
// while the receiver stalls, and only the next end-of-frame waits for it.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// sum and counters, and makes the next frame load the smoothed mean directly.
module frame_luminance_meter import flm_pkg::*; #(
    parameter int COMPONENT_BITS   = 16,
    parameter int MAX_FRAME_PIXELS = 4194304
) (
    input  logic                aclk,
    input  logic                aresetn,
    // pixel words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COMP_W-1:0]   s_comp0,
    input  logic [COMP_W-1:0]   s_comp1,
    input  logic [COMP_W-1:0]   s_comp2,
    input  logic                s_end_of_frame,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MEAN_W-1:0]   m_frame_mean,
    output logic [MEAN_W-1:0]   m_smoothed_mean,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [FMT_W-1:0]     fmt_reg;
    logic [CFG_PIX_W-1:0] step_reg, count_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic                 m_valid_reg;
    logic [MEAN_W-1:0]    mean_out_reg, avg_out_reg;

    logic                 cfg_wr, out_free;
    logic [1:0]           reg_idx;
    ctrl_t                ctrl;
    stat_t                stat;
    logic [MEAN_W-1:0]    frame_mean, smoothed_mean;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= RST_FORMAT;
            step_reg  <= RST_STEP;
            count_reg <= RST_COUNT;
            rate_reg  <= RST_RATE;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FORMAT: fmt_reg   <= pwdata[FMT_W-1:0];
                REG_STEP:   step_reg  <= pwdata[CFG_PIX_W-1:0];
                REG_COUNT:  count_reg <= pwdata[CFG_PIX_W-1:0];
                REG_RATE:   rate_reg  <= pwdata[RATE_W-1:0];
                default:    fmt_reg   <= fmt_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FORMAT: prdata = DATA_W'(fmt_reg);
            REG_STEP:   prdata = DATA_W'(step_reg);
            REG_COUNT:  prdata = DATA_W'(count_reg);
            REG_RATE:   prdata = DATA_W'(rate_reg);
            default:    prdata = '0;
        endcase
    end

    // result register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            mean_out_reg <= frame_mean;
            avg_out_reg  <= smoothed_mean;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_mean    = mean_out_reg;
    assign m_smoothed_mean = avg_out_reg;

    flm_seq u_seq (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_ready),
        .ctrl     (ctrl)
    );

    flm_datapath #(
        .COMPONENT_BITS   (COMPONENT_BITS),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_datapath (
        .clk           (aclk),
        .rstn          (aresetn),
        .ctrl          (ctrl),
        .comp0         (s_comp0),
        .comp1         (s_comp1),
        .comp2         (s_comp2),
        .end_of_frame  (s_end_of_frame),
        .cfg_format    (fmt_reg),
        .cfg_step      (step_reg),
        .cfg_count     (count_reg),
        .cfg_rate      (rate_reg),
        .stat          (stat),
        .frame_mean    (frame_mean),
        .smoothed_mean (smoothed_mean)
    );

endmodule
